@@ rtl/core/cdq_pkg.sv @@
// Package for the circular deque: request and status codes, word width,
// and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package cdq_pkg;

	localparam int unsigned WORD_W = 32;

	// Request kinds.
	localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
	localparam logic [1:0] REQ_PUSH_REAR  = 2'd1;
	localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
	localparam logic [1:0] REQ_POP_REAR   = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_req;
		logic exec;
		logic load_out;
	} cdq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
	} cdq_sts_t;

endpackage

@@ rtl/core/cdq_req_if.sv @@
// Request channel of the circular deque: valid/ready with request payload.
// Depends on cdq_pkg.
`timescale 1ns / 1ps

interface cdq_req_if import cdq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [1:0]               req_type;
	logic signed [WORD_W-1:0] push_value;

	modport source (output valid, input ready, output req_type, output push_value);
	modport sink   (input valid, output ready, input req_type, input push_value);
endinterface

@@ rtl/core/cdq_rsp_if.sv @@
// Response channel of the circular deque: valid/ready with result payload.
// Depends on cdq_pkg.
`timescale 1ns / 1ps

interface cdq_rsp_if import cdq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] pop_value;
	logic [1:0]               status;
	logic                     now_empty;
	logic                     now_full;

	modport source (output valid, input ready, output pop_value, output status,
		output now_empty, output now_full);
	modport sink   (input valid, output ready, input pop_value, input status,
		input now_empty, input now_full);
endinterface

@@ rtl/core/cdq_ctrl.sv @@
// Controller of the circular deque: sequences accept, execute and deliver.
// Depends on cdq_pkg.
`timescale 1ns / 1ps

module cdq_ctrl import cdq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output cdq_cmd_t cmd,
	input  cdq_sts_t sts
);

	typedef enum logic [1:0] {
		IDLE,
		EXEC,
		DELIVER
	} state_t;

	state_t state_q;
	logic   ready_q;

	// State register and the registered ready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				IDLE: begin
					if (req_valid && ready_q) begin
						state_q <= EXEC;
						ready_q <= 1'b0;
					end
				end
				EXEC: begin
					state_q <= DELIVER;
				end
				DELIVER: begin
					if (sts.out_free) begin
						state_q <= IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	// Commands follow from the state.
	assign req_ready    = ready_q;
	assign cmd.load_req = req_valid && ready_q;
	assign cmd.exec     = (state_q == EXEC);
	assign cmd.load_out = (state_q == DELIVER) && sts.out_free;

endmodule

@@ rtl/core/cdq_datapath.sv @@
// Datapath of the circular deque: ring pointers, slot memory and result register.
// Depends on cdq_pkg.
`timescale 1ns / 1ps

module cdq_datapath import cdq_pkg::*; #(
	parameter int unsigned DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cdq_cmd_t                 cmd,
	output cdq_sts_t                 sts,
	input  logic [1:0]               req_type,
	input  logic signed [WORD_W-1:0] push_value,
	input  logic                     rsp_ready,
	output logic                     rsp_valid,
	output logic signed [WORD_W-1:0] pop_value,
	output logic [1:0]               status,
	output logic                     now_empty,
	output logic                     now_full
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
		return (i == LAST) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
		return (i == '0) ? LAST : i - 1'b1;
	endfunction

	logic [1:0]               req_type_q;
	logic signed [WORD_W-1:0] push_value_q;
	logic [AW-1:0]            head_q, tail_q;
	logic [AW-1:0]            head_n, tail_n;
	logic [1:0]               status_n, status_q;
	logic                     pop_ok_n, pop_ok_q;
	logic                     wr_en, rd_en;
	logic [AW-1:0]            wr_addr, rd_addr;
	logic [WORD_W-1:0]        mem_q [DEPTH];
	logic [WORD_W-1:0]        rd_data_q;
	logic                     is_empty, is_full;
	logic                     out_valid_q;
	logic signed [WORD_W-1:0] pop_value_q;
	logic [1:0]               out_status_q;
	logic                     now_empty_q, now_full_q;

	// Request holding register.
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_type_q   <= req_type;
			push_value_q <= push_value;
		end
	end

	assign is_empty = (head_q == tail_q);
	assign is_full  = (ring_next(tail_q) == head_q);

	// Decide the slot access and pointer moves for the held request.
	always_comb begin
		head_n   = head_q;
		tail_n   = tail_q;
		status_n = ST_DONE;
		pop_ok_n = 1'b0;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		wr_addr  = head_q;
		rd_addr  = tail_q;
		case (req_type_q)
			REQ_PUSH_FRONT: begin
				if (is_full) begin
					status_n = ST_FULL;
				end else begin
					wr_en   = cmd.exec;
					wr_addr = head_q;
					head_n  = ring_prev(head_q);
				end
			end
			REQ_PUSH_REAR: begin
				if (is_full) begin
					status_n = ST_FULL;
				end else begin
					wr_en   = cmd.exec;
					wr_addr = ring_next(tail_q);
					tail_n  = ring_next(tail_q);
				end
			end
			REQ_POP_FRONT: begin
				if (is_empty) begin
					status_n = ST_EMPTY;
				end else begin
					rd_en    = cmd.exec;
					pop_ok_n = 1'b1;
					rd_addr  = ring_next(head_q);
					head_n   = ring_next(head_q);
				end
			end
			default: begin
				if (is_empty) begin
					status_n = ST_EMPTY;
				end else begin
					rd_en    = cmd.exec;
					pop_ok_n = 1'b1;
					rd_addr  = tail_q;
					tail_n   = ring_prev(tail_q);
				end
			end
		endcase
	end

	// Ring pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (cmd.exec) begin
			head_q <= head_n;
			tail_q <= tail_n;
		end
	end

	// Outcome of the executed request, held until delivery.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= status_n;
			pop_ok_q <= pop_ok_n;
		end
	end

	// Slot memory with one write port and a registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= push_value_q;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// Result register; it frees up when the current result is transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			pop_value_q  <= pop_ok_q ? rd_data_q : '0;
			out_status_q <= status_q;
			now_empty_q  <= is_empty;
			now_full_q   <= is_full;
		end
	end

	assign sts.out_free = !out_valid_q || rsp_ready;
	assign rsp_valid    = out_valid_q;
	assign pop_value    = pop_value_q;
	assign status       = out_status_q;
	assign now_empty    = now_empty_q;
	assign now_full     = now_full_q;

endmodule

@@ rtl/core/circular_deque.sv @@
// Circular deque top level: a ring of DEPTH words holding up to DEPTH-1 values.
// Each request goes through the controller's accept, execute and deliver states,
// the slot memory read being registered in execute. Deliver waits for a free output,
// and a new request is accepted only once its result is in the result register.
// The next request is taken while a finished result still waits on the output.
// Reset (arst_n low) empties the deque at once; the slot memory is not cleared.
`timescale 1ns / 1ps

module circular_deque import cdq_pkg::*; #(
	parameter int unsigned DEPTH = 128
) (
	input  logic     clk,
	input  logic     arst_n,
	cdq_req_if.sink  req,
	cdq_rsp_if.source rsp
);

	cdq_cmd_t cmd;
	cdq_sts_t sts;

	// Sequencing of each request.
	cdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Pointers, storage and result register.
	cdq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.req_type   (req.req_type),
		.push_value (req.push_value),
		.rsp_ready  (rsp.ready),
		.rsp_valid  (rsp.valid),
		.pop_value  (rsp.pop_value),
		.status     (rsp.status),
		.now_empty  (rsp.now_empty),
		.now_full   (rsp.now_full)
	);

endmodule

@@ rtl/core/cdq_checker.sv @@
// Port-level checks for the circular deque, bound to the top level.
// Depends on cdq_pkg and circular_deque.
`timescale 1ns / 1ps

module cdq_checker import cdq_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [WORD_W-1:0] pop_value,
	input logic [1:0]        status,
	input logic              now_empty,
	input logic              now_full
);

	// A stalled result stays offered.
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result withdrawn before transfer");

	// A stalled result keeps its payload.
	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(pop_value) && $stable(status))
		else $error("result payload changed while stalled");

	// A refused push leaves the deque full and not empty, and returns zero.
	a_full_refusal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> now_full && !now_empty && pop_value == '0)
		else $error("full refusal without a full deque");

	// A refused pop leaves the deque empty and returns zero.
	a_empty_refusal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_EMPTY |-> now_empty && pop_value == '0)
		else $error("empty refusal without an empty deque");

	// The deque is never reported empty and full together.
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(now_empty && now_full))
		else $error("empty and full reported together");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.pop_value (rsp.pop_value),
	.status    (rsp.status),
	.now_empty (rsp.now_empty),
	.now_full  (rsp.now_full)
);

@@ verif/circular_deque_test.sv @@
// Self-checking testbench for circular_deque: directed and random push/pop
// requests under several idle and stall phases, checked by a scoreboard.
// Depends on cdq_pkg, cdq_req_if, cdq_rsp_if and circular_deque.
`timescale 1ns / 1ps

module circular_deque_test;
	import cdq_pkg::*;

	localparam int unsigned DEPTH        = 128;
	localparam int unsigned QUIET_LIMIT  = 4000;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned PHASE_ITEMS  = 225;

	// Scoreboard: tracks its own copy of the ring and queues the expected results.
	class deque_scoreboard;
		typedef struct packed {
			logic signed [WORD_W-1:0] pop_value;
			logic [1:0]               status;
			logic                     now_empty;
			logic                     now_full;
		} deque_result_t;

		int unsigned       head_idx;
		int unsigned       tail_idx;
		logic [WORD_W-1:0] ring [DEPTH];
		deque_result_t     awaited [$];
		int unsigned       mismatches;
		int unsigned       requests;
		int unsigned       results;
		int unsigned       full_refusals;
		int unsigned       empty_refusals;
		int unsigned       full_hits;

		function bit is_empty();
			return head_idx == tail_idx;
		endfunction

		function bit is_full();
			return ((tail_idx + 1) % DEPTH) == head_idx;
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		// Apply one accepted request to the ring and queue the result it must give.
		function void note_request(logic [1:0] kind, logic [WORD_W-1:0] word);
			deque_result_t r;
			r = '0;
			r.status = ST_DONE;
			requests++;
			case (kind)
			REQ_PUSH_FRONT: begin
				if (is_full()) begin
					r.status = ST_FULL;
					full_refusals++;
				end else begin
					ring[head_idx] = word;
					head_idx = (head_idx + DEPTH - 1) % DEPTH;
				end
			end
			REQ_PUSH_REAR: begin
				if (is_full()) begin
					r.status = ST_FULL;
					full_refusals++;
				end else begin
					tail_idx = (tail_idx + 1) % DEPTH;
					ring[tail_idx] = word;
				end
			end
			REQ_POP_FRONT: begin
				if (is_empty()) begin
					r.status = ST_EMPTY;
					empty_refusals++;
				end else begin
					head_idx = (head_idx + 1) % DEPTH;
					r.pop_value = ring[head_idx];
				end
			end
			default: begin
				if (is_empty()) begin
					r.status = ST_EMPTY;
					empty_refusals++;
				end else begin
					r.pop_value = ring[tail_idx];
					tail_idx = (tail_idx + DEPTH - 1) % DEPTH;
				end
			end
			endcase
			r.now_empty = is_empty();
			r.now_full  = is_full();
			if (r.now_full)
				full_hits++;
			awaited.push_back(r);
		endfunction

		// Printing stops after 40 mismatches so a broken block cannot flood the log.
		task report_mismatch(string msg);
			mismatches++;
			if (mismatches <= 40)
				$display("ERROR at %0t ns: %s", $time, msg);
		endtask

		// Compare one delivered result with the oldest expectation.
		task check_result(logic signed [WORD_W-1:0] pop_value, logic [1:0] status,
			logic now_empty, logic now_full);
			deque_result_t want;
			results++;
			if (awaited.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with no request outstanding",
					results));
			end else begin
				want = awaited.pop_front();
				if (pop_value !== want.pop_value)
					report_mismatch($sformatf("result %0d: pop_value %0d, expected %0d",
						results, pop_value, want.pop_value));
				if (status !== want.status)
					report_mismatch($sformatf("result %0d: status %0d, expected %0d",
						results, status, want.status));
				if (now_empty !== want.now_empty)
					report_mismatch($sformatf("result %0d: now_empty %b, expected %b",
						results, now_empty, want.now_empty));
				if (now_full !== want.now_full)
					report_mismatch($sformatf("result %0d: now_full %b, expected %b",
						results, now_full, want.now_full));
			end
		endtask
	endclass

	logic            clk;
	logic            arst_n;
	deque_scoreboard sb;
	int unsigned     send_idle_pct;
	int unsigned     recv_stall_pct;
	int unsigned     quiet_cycles;
	bit              filling;

	cdq_req_if req_ch ();
	cdq_rsp_if rsp_ch ();

	circular_deque #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Clock with a 2 ns period.
	initial clk = 1'b0;
	always #1ns clk = ~clk;

	// The receiver stalls at random, at the rate of the current phase.
	always @(negedge clk) begin
		rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
	end

	// Transfers are sampled at the rising edge; a long quiet stretch means a hang.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				sb.note_request(req_ch.req_type, req_ch.push_value);
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_result(rsp_ch.pop_value, rsp_ch.status, rsp_ch.now_empty,
					rsp_ch.now_full);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
				$display("circular_deque: mismatch");
				$finish;
			end
		end
	end

	// Offer one request after a random gap and hold it until the transfer.
	task automatic send_request(input logic [1:0] kind, input logic [WORD_W-1:0] word);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid      = 1'b1;
		req_ch.req_type   = kind;
		req_ch.push_value = word;
		do
			@(posedge clk);
		while (!req_ch.ready);
		@(negedge clk);
	endtask

	// Mostly pushes while filling and mostly pops while draining, with some noise.
	function automatic logic [1:0] pick_kind();
		int unsigned roll;
		bit          push_side;
		roll = $urandom_range(99);
		if (roll < 10)
			return 2'($urandom_range(3));
		push_side = filling ? (roll < 87) : (roll >= 87);
		if (push_side)
			return $urandom_range(1) ? REQ_PUSH_REAR : REQ_PUSH_FRONT;
		return $urandom_range(1) ? REQ_POP_REAR : REQ_POP_FRONT;
	endfunction

	// Random requests that sweep the deque between empty and full.
	task automatic run_random(input int unsigned count);
		for (int unsigned i = 0; i < count; i++) begin
			if (sb.is_full())
				filling = 1'b0;
			else if (sb.is_empty())
				filling = 1'b1;
			send_request(pick_kind(), $urandom);
		end
	endtask

	initial begin
		sb                = new();
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.req_type   = REQ_PUSH_FRONT;
		req_ch.push_value = '0;
		rsp_ch.ready      = 1'b0;
		send_idle_pct     = 0;
		recv_stall_pct    = 0;
		filling           = 1'b1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: pops on an empty deque, extreme words, both ends, wrap at zero.
		send_request(REQ_POP_FRONT, $urandom);
		send_request(REQ_POP_REAR, $urandom);
		send_request(REQ_PUSH_FRONT, 32'h7FFF_FFFF);
		send_request(REQ_PUSH_REAR, 32'h8000_0000);
		send_request(REQ_PUSH_FRONT, 32'h0000_0000);
		send_request(REQ_PUSH_REAR, 32'hFFFF_FFFF);
		send_request(REQ_POP_REAR, $urandom);
		send_request(REQ_PUSH_FRONT, 32'h5555_5555);
		send_request(REQ_PUSH_REAR, 32'hAAAA_AAAA);
		repeat (5) send_request(REQ_POP_FRONT, $urandom);
		send_request(REQ_POP_FRONT, $urandom);
		send_request(REQ_POP_REAR, $urandom);
		send_request(REQ_PUSH_REAR, 32'h0000_0001);
		send_request(REQ_POP_FRONT, $urandom);
		send_request(REQ_PUSH_FRONT, 32'h0000_0002);
		send_request(REQ_POP_REAR, $urandom);

		// Random phases: no idling, idle sender, stalling receiver, then both.
		run_random(PHASE_ITEMS);
		send_idle_pct = 68;
		run_random(PHASE_ITEMS);
		send_idle_pct  = 0;
		recv_stall_pct = 68;
		run_random(PHASE_ITEMS);
		send_idle_pct  = 31;
		recv_stall_pct = 31;
		run_random(PHASE_ITEMS);
		req_ch.valid = 1'b0;

		// Drain outstanding results, then let the pipeline settle.
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("circular_deque_test: %0d requests and %0d results checked in four phases,",
			sb.requests, sb.results);
		$display("  %0d pushes refused full, %0d pops refused empty, %0d results left it full",
			sb.full_refusals, sb.empty_refusals, sb.full_hits);
		if (sb.mismatches == 0) begin
			$display("circular_deque: match");
		end else begin
			$display("%0d field mismatches", sb.mismatches);
			$display("circular_deque: mismatch");
		end
		$finish;
	end

endmodule
